@@ hdl/bitmap_page_allocator_top_macros.svh @@
// Assertion macros for the bitmap page allocator checker.
// Expects signals named clk and rst_n in the scope of use.
`ifndef BITMAP_PAGE_ALLOCATOR_TOP_MACROS_SVH
`define BITMAP_PAGE_ALLOCATOR_TOP_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define BPA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define BPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/bpa_pkg.sv @@
// Shared types and constants of the bitmap page allocator.
// No dependencies.
package bpa_pkg;

  localparam int REQ_W      = 2;
  localparam int ADDR_W     = 32;
  localparam int LEN_W      = 32;
  localparam int PADDR_W    = 27;
  localparam int COUNT_W    = 16;
  localparam int TP_W       = 16;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic [TP_W-1:0]    TOTAL_PAGES_RST = 16'd32768;
  localparam logic [COUNT_W-1:0] COUNT_MAX       = 16'hFFFF;

  // register index (paddr[2])
  localparam logic REG_TOTAL_PAGES = 1'b0;

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_FREE    = 2'd1,
    REQ_RESERVE = 2'd2,
    REQ_RELEASE = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    WOP_ALLOC,
    WOP_SET,
    WOP_CLR
  } wop_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_PREP,
    ST_CLAMP,
    ST_DIV,
    ST_ARD,
    ST_ACHK,
    ST_RD,
    ST_WR,
    ST_DONE
  } state_t;

endpackage

@@ hdl/bpa_if.sv @@
// Valid/ready channel interfaces for requests and results.
// Depends on bpa_pkg for field widths.
interface bpa_in_if;
  logic                           valid;
  logic                           ready;
  logic [bpa_pkg::REQ_W-1:0]      req_type;
  logic [bpa_pkg::ADDR_W-1:0]     addr;
  logic [bpa_pkg::LEN_W-1:0]      len;

  modport source (output valid, req_type, addr, len, input ready);
  modport sink   (input valid, req_type, addr, len, output ready);
endinterface

interface bpa_out_if;
  logic                           valid;
  logic                           ready;
  logic [bpa_pkg::PADDR_W-1:0]    page_addr;
  logic                           ok;
  logic [bpa_pkg::COUNT_W-1:0]    used_count;

  modport source (output valid, page_addr, ok, used_count, input ready);
  modport sink   (input valid, page_addr, ok, used_count, output ready);
endinterface

@@ hdl/bpa_div.sv @@
// Page number split into bitmap word index and bit offset.
// DIVISOR is a power of two, so the quotient is a shift and the remainder a mask;
// the result is registered and done pulses in the cycle after start. No package use.
module bpa_div #(
  parameter int DVD_W   = 16,
  parameter int DIVISOR = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  output logic             done,
  output logic [DVD_W-1:0] quo,
  output logic [$clog2(DIVISOR)-1:0] rem
);

  localparam int RM_W = $clog2(DIVISOR);

  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [RM_W-1:0]  rem_r, rem_nxt;
  logic             done_r, done_nxt;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    done_nxt = start;
    if (start) begin
      quo_nxt = dividend >> RM_W;
      rem_nxt = dividend[RM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

@@ hdl/bpa_word_unit.sv @@
// Shared bitmap word unit: range mask, set/clear, lowest free bit search.
// Depends on bpa_pkg for the operation codes.
module bpa_word_unit #(
  parameter int WB = 32
) (
  input  bpa_pkg::wop_t                op,
  input  logic [WB-1:0]                data,
  input  logic [$clog2(WB)-1:0]        lo,
  input  logic [$clog2(WB+1)-1:0]      hi,
  output logic [WB-1:0]                new_data,
  output logic                         found,
  output logic [$clog2(WB)-1:0]        idx
);

  localparam int WB_W = $clog2(WB);
  localparam int HI_W = $clog2(WB + 1);

  logic [WB-1:0] mask;
  logic [WB-1:0] cand;
  logic [WB-1:0] onehot;

  // bits lo .. hi-1
  assign mask  = ({WB{1'b1}} << lo) & ({WB{1'b1}} >> (HI_W'(WB) - hi));
  assign cand  = ~data & mask;
  assign found = |cand;

  always_comb begin
    idx = '0;
    for (int i = WB - 1; i >= 0; i--) begin
      if (cand[i]) idx = WB_W'(i);
    end
  end

  assign onehot = {{(WB-1){1'b0}}, 1'b1} << idx;

  always_comb begin
    case (op)
      bpa_pkg::WOP_ALLOC: new_data = found ? (data | onehot) : data;
      bpa_pkg::WOP_SET:   new_data = data | mask;
      bpa_pkg::WOP_CLR:   new_data = data & ~mask;
      default:            new_data = data;
    endcase
  end

endmodule

@@ hdl/bitmap_page_allocator_top.sv @@
// First-fit bitmap page allocator. After reset an init pass writes the
// whole bitmap to "used", one word per cycle; in_if.ready stays low during
// that pass while the cfg port already takes writes. Requests are handled
// one at a time and in_if.ready is high only while idle. Allocate reads and
// checks one bitmap word after another through the word holding the first
// free page; free page and region requests read and write back each word
// touched, and an out-of-range free or an empty region touches no word.
// A result held by out_if.ready low stalls the block in its done state.
// WORD_BITS must be a power of two. All bitmap traffic goes through one
// memory port and one shared word unit.
// Depends on bpa_pkg, bpa_if, bpa_div and bpa_word_unit.
module bitmap_page_allocator_top #(
  parameter int NUM_PAGES  = 32768,
  parameter int PAGE_SHIFT = 12,
  parameter int WORD_BITS  = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  bpa_in_if.sink                            in_if,
  bpa_out_if.source                         out_if,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [bpa_pkg::APB_ADDR_W-1:0]    cfg_paddr,
  input  logic [bpa_pkg::APB_DATA_W-1:0]    cfg_pwdata,
  output logic [bpa_pkg::APB_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);

  localparam int PG_BYTES  = 1 << PAGE_SHIFT;
  localparam int BW        = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int WA_W      = (BW > 1) ? $clog2(BW) : 1;
  localparam int PG_W      = $clog2(NUM_PAGES + 1);
  localparam int WB_W      = $clog2(WORD_BITS);
  localparam int HI_W      = $clog2(WORD_BITS + 1);
  localparam int FR_W      = bpa_pkg::ADDR_W - PAGE_SHIFT;
  localparam int ER_W      = bpa_pkg::ADDR_W + 2 - PAGE_SHIFT;
  localparam int CMP_W     = (PG_W > bpa_pkg::TP_W) ? PG_W : bpa_pkg::TP_W;
  localparam int X_W       = ((ER_W > PG_W) ? ER_W : PG_W) + 1;
  localparam int BS_W      = PG_W + 1;
  localparam int PA_W      = BS_W + PAGE_SHIFT + bpa_pkg::PADDR_W;
  localparam int SUM_W     = bpa_pkg::ADDR_W + 1;

  localparam logic [WA_W-1:0] LAST_WORD = WA_W'(BW - 1);

  // ---------------- configuration ----------------
  logic [bpa_pkg::TP_W-1:0] total_pages_r;
  logic                     cfg_wr;
  logic                     cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[bpa_pkg::APB_ADDR_W-1];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_idx == bpa_pkg::REG_TOTAL_PAGES)
                      ? bpa_pkg::APB_DATA_W'(total_pages_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_pages_r <= bpa_pkg::TOTAL_PAGES_RST;
    end else if (cfg_wr && cfg_idx == bpa_pkg::REG_TOTAL_PAGES) begin
      total_pages_r <= cfg_pwdata[bpa_pkg::TP_W-1:0];
    end
  end

  logic [CMP_W-1:0] tp_ext;
  logic [PG_W-1:0]  lim;

  assign tp_ext = CMP_W'(total_pages_r);
  assign lim    = (tp_ext < CMP_W'(NUM_PAGES)) ? PG_W'(tp_ext) : PG_W'(NUM_PAGES);

  // ---------------- registers ----------------
  bpa_pkg::state_t state_r, state_nxt;

  bpa_pkg::req_t                 req_r, req_nxt;
  logic [bpa_pkg::ADDR_W-1:0]    addr_r, addr_nxt;
  logic [bpa_pkg::LEN_W-1:0]     len_r, len_nxt;
  logic [FR_W-1:0]               first_r, first_nxt;
  logic [ER_W-1:0]               end_raw_r, end_raw_nxt;
  logic [PG_W-1:0]               end_r, end_nxt;
  logic [WA_W-1:0]               word_r, word_nxt;
  logic [BS_W-1:0]               base_r, base_nxt;
  logic [WB_W-1:0]               lo_r, lo_nxt;
  logic                          ok_r, ok_nxt;
  logic [bpa_pkg::PADDR_W-1:0]   paddr_r, paddr_nxt;
  logic [bpa_pkg::COUNT_W-1:0]   cnt_r, cnt_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [bpa_pkg::PADDR_W-1:0]   out_paddr_r;
  logic                          out_ok_r;
  logic [bpa_pkg::COUNT_W-1:0]   out_cnt_r;

  // ---------------- bitmap memory ----------------
  logic [WORD_BITS-1:0] bitmap_mem [BW];
  logic [WORD_BITS-1:0] rd_data_r;
  logic                 mem_we, mem_re;
  logic [WORD_BITS-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) bitmap_mem[word_r] <= mem_wdata;
    if (mem_re) rd_data_r <= bitmap_mem[word_r];
  end

  // ---------------- shared units ----------------
  logic             div_start, div_done;
  logic [PG_W-1:0]  div_quo;
  logic [WB_W-1:0]  div_rem;

  bpa_div #(
    .DVD_W   (PG_W),
    .DIVISOR (WORD_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (PG_W'(first_r)),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  bpa_pkg::wop_t        wu_op;
  logic [WB_W-1:0]      wu_lo;
  logic [HI_W-1:0]      wu_hi;
  logic [WORD_BITS-1:0] wu_data;
  logic                 wu_found;
  logic [WB_W-1:0]      wu_idx;

  bpa_word_unit #(
    .WB (WORD_BITS)
  ) u_word (
    .op       (wu_op),
    .data     (rd_data_r),
    .lo       (wu_lo),
    .hi       (wu_hi),
    .new_data (wu_data),
    .found    (wu_found),
    .idx      (wu_idx)
  );

  // ---------------- datapath helpers ----------------
  logic             in_fire;
  logic             out_load;
  logic [SUM_W-1:0] top_sum;
  logic [SUM_W:0]   top_up;
  logic [X_W-1:0]   end_x, lim_x, end_c_x;
  logic             empty;
  logic [BS_W-1:0]  bound, diff;
  logic             last_word;
  logic             at_lim;
  logic [BS_W-1:0]  page;
  logic [PA_W-1:0]  pa_full;

  assign in_fire  = in_if.valid && in_if.ready;
  assign out_load = (state_r == bpa_pkg::ST_DONE) && (!out_valid_r || out_if.ready);

  assign top_sum = SUM_W'(addr_r) + SUM_W'(len_r);
  assign top_up  = (SUM_W+1)'(top_sum) + (SUM_W+1)'(PG_BYTES - 1);

  assign end_x   = X_W'(end_raw_r);
  assign lim_x   = X_W'(lim);
  assign end_c_x = (end_x < lim_x) ? end_x : lim_x;
  assign empty   = X_W'(first_r) >= end_c_x;

  // upper page bound of the current word walk
  assign bound     = (state_r == bpa_pkg::ST_ACHK) ? BS_W'(lim) : BS_W'(end_r);
  assign diff      = bound - base_r;
  assign last_word = diff <= BS_W'(WORD_BITS);
  assign at_lim    = base_r >= BS_W'(lim);

  assign page    = base_r + BS_W'(wu_idx);
  assign pa_full = PA_W'(page) << PAGE_SHIFT;

  assign wu_hi = last_word ? HI_W'(diff) : HI_W'(WORD_BITS);
  assign wu_lo = (state_r == bpa_pkg::ST_ACHK) ? '0 : lo_r;
  always_comb begin
    if (state_r == bpa_pkg::ST_ACHK)       wu_op = bpa_pkg::WOP_ALLOC;
    else if (req_r == bpa_pkg::REQ_RESERVE) wu_op = bpa_pkg::WOP_SET;
    else                                    wu_op = bpa_pkg::WOP_CLR;
  end

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bpa_pkg::ST_INIT:  if (word_r == LAST_WORD) state_nxt = bpa_pkg::ST_IDLE;
      bpa_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (bpa_pkg::req_t'(in_if.req_type) == bpa_pkg::REQ_ALLOC) begin
            state_nxt = bpa_pkg::ST_ARD;
          end else begin
            state_nxt = bpa_pkg::ST_PREP;
          end
        end
      end
      bpa_pkg::ST_PREP:  state_nxt = bpa_pkg::ST_CLAMP;
      bpa_pkg::ST_CLAMP: state_nxt = empty ? bpa_pkg::ST_DONE : bpa_pkg::ST_DIV;
      bpa_pkg::ST_DIV:   if (div_done) state_nxt = bpa_pkg::ST_RD;
      bpa_pkg::ST_ARD:   state_nxt = at_lim ? bpa_pkg::ST_DONE : bpa_pkg::ST_ACHK;
      bpa_pkg::ST_ACHK:  state_nxt = wu_found ? bpa_pkg::ST_DONE : bpa_pkg::ST_ARD;
      bpa_pkg::ST_RD:    state_nxt = bpa_pkg::ST_WR;
      bpa_pkg::ST_WR:    state_nxt = last_word ? bpa_pkg::ST_DONE : bpa_pkg::ST_RD;
      bpa_pkg::ST_DONE:  if (out_load) state_nxt = bpa_pkg::ST_IDLE;
      default:           state_nxt = bpa_pkg::ST_INIT;
    endcase
  end

  // ---------------- outputs and datapath ----------------
  always_comb begin
    req_nxt     = req_r;
    addr_nxt    = addr_r;
    len_nxt     = len_r;
    first_nxt   = first_r;
    end_raw_nxt = end_raw_r;
    end_nxt     = end_r;
    word_nxt    = word_r;
    base_nxt    = base_r;
    lo_nxt      = lo_r;
    ok_nxt      = ok_r;
    paddr_nxt   = paddr_r;
    cnt_nxt     = cnt_r;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_wdata   = wu_data;
    div_start   = 1'b0;
    in_if.ready = 1'b0;

    case (state_r)
      bpa_pkg::ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = {WORD_BITS{1'b1}};
        word_nxt  = word_r + 1'b1;
      end
      bpa_pkg::ST_IDLE: begin
        in_if.ready = 1'b1;
        if (in_fire) begin
          req_nxt   = bpa_pkg::req_t'(in_if.req_type);
          addr_nxt  = in_if.addr;
          len_nxt   = in_if.len;
          word_nxt  = '0;
          base_nxt  = '0;
          ok_nxt    = 1'b0;
          paddr_nxt = '0;
        end
      end
      bpa_pkg::ST_PREP: begin
        first_nxt = addr_r[bpa_pkg::ADDR_W-1:PAGE_SHIFT];
        case (req_r)
          bpa_pkg::REQ_RESERVE: end_raw_nxt = ER_W'(top_up >> PAGE_SHIFT);
          bpa_pkg::REQ_RELEASE: end_raw_nxt = ER_W'(top_sum >> PAGE_SHIFT);
          // single page free walks as a one-page release
          default: end_raw_nxt = ER_W'(addr_r[bpa_pkg::ADDR_W-1:PAGE_SHIFT]) + 1'b1;
        endcase
      end
      bpa_pkg::ST_CLAMP: begin
        end_nxt = PG_W'(end_c_x);
        if (empty) begin
          ok_nxt = (req_r != bpa_pkg::REQ_FREE);
        end else begin
          div_start = 1'b1;
        end
      end
      bpa_pkg::ST_DIV: begin
        if (div_done) begin
          word_nxt = WA_W'(div_quo);
          lo_nxt   = div_rem;
          base_nxt = BS_W'(PG_W'(first_r)) - BS_W'(div_rem);
        end
      end
      bpa_pkg::ST_ARD: begin
        mem_re = !at_lim;
      end
      bpa_pkg::ST_ACHK: begin
        if (wu_found) begin
          mem_we    = 1'b1;
          ok_nxt    = 1'b1;
          paddr_nxt = pa_full[bpa_pkg::PADDR_W-1:0];
          if (cnt_r != bpa_pkg::COUNT_MAX) cnt_nxt = cnt_r + 1'b1;
        end else begin
          word_nxt = word_r + 1'b1;
          base_nxt = base_r + BS_W'(WORD_BITS);
        end
      end
      bpa_pkg::ST_RD: begin
        mem_re = 1'b1;
      end
      bpa_pkg::ST_WR: begin
        mem_we = 1'b1;
        if (last_word) begin
          ok_nxt = 1'b1;
          if (req_r == bpa_pkg::REQ_FREE && cnt_r != '0) cnt_nxt = cnt_r - 1'b1;
        end else begin
          word_nxt = word_r + 1'b1;
          base_nxt = base_r + BS_W'(WORD_BITS);
          lo_nxt   = '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && !out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bpa_pkg::ST_INIT;
      word_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      word_r      <= word_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    addr_r    <= addr_nxt;
    len_r     <= len_nxt;
    first_r   <= first_nxt;
    end_raw_r <= end_raw_nxt;
    end_r     <= end_nxt;
    base_r    <= base_nxt;
    lo_r      <= lo_nxt;
    ok_r      <= ok_nxt;
    paddr_r   <= paddr_nxt;
    if (out_load) begin
      out_paddr_r <= paddr_r;
      out_ok_r    <= ok_r;
      out_cnt_r   <= cnt_r;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.page_addr  = out_paddr_r;
  assign out_if.ok         = out_ok_r;
  assign out_if.used_count = out_cnt_r;

endmodule

@@ hdl/bpa_checker.sv @@
// Port-level checker for the bitmap page allocator, bound to the top level.
// Depends on bitmap_page_allocator_top_macros.svh.
`include "bitmap_page_allocator_top_macros.svh"

module bpa_checker #(
  parameter int PAGE_SHIFT = 12
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [bpa_pkg::PADDR_W-1:0]    out_page_addr,
  input logic                           out_ok
);

  `BPA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result lost before transfer")
  `BPA_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "request taken while busy")
  `BPA_ASSERT_SAME(a_addr_needs_ok, out_valid && (out_page_addr != '0), out_ok, "address without ok")
  `BPA_ASSERT_SAME(a_addr_aligned, out_valid, out_page_addr[PAGE_SHIFT-1:0] == '0, "address not aligned")

endmodule

bind bitmap_page_allocator_top bpa_checker #(
  .PAGE_SHIFT (PAGE_SHIFT)
) u_bpa_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_if.valid),
  .in_ready      (in_if.ready),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .out_page_addr (out_if.page_addr),
  .out_ok        (out_if.ok)
);
